### sv/spwl_pkg.sv
`timescale 1ns / 1ps

package spwl_pkg;

    // field widths
    localparam int MZ_W       = 32;
    localparam int INT_W      = 32;
    localparam int PPM_W      = 14;
    localparam int BEST_IDX_W = 10;
    localparam int OUT_CNT_W  = 11;

    localparam logic [PPM_W-1:0] PPM_RESET = 14'd160;

    // window half width: floor(mz * ppm / 16e6) = floor((mz * ppm >> 10) / 15625)
    localparam int PROD_W      = MZ_W + PPM_W;
    localparam int WIN_SHIFT   = 10;
    localparam int WIN_DIVISOR = 15625;
    localparam int DVD_W       = PROD_W - WIN_SHIFT;
    localparam int DELTA_W     = 23;

    // quotient estimate by reciprocal floor(2^40 / 15625), short by at most one
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 40;
    localparam int SPLIT_W     = 18;
    localparam int PART_W      = SPLIT_W + RECIP_W;
    localparam int FULL_W      = DVD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] WIN_RECIP = 27'd70368744;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_WINDOW = 2'd2,
        OP_RANGE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [MZ_W-1:0]  mz_value;
        logic [MZ_W-1:0]  mz_upper;
        logic [INT_W-1:0] peak_intensity;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic                  found;
        logic [BEST_IDX_W-1:0] best_index;
        logic [INT_W-1:0]      best_intensity;
        logic [OUT_CNT_W-1:0]  first_index;
        logic [OUT_CNT_W-1:0]  match_count;
    } rsp_t;

    typedef struct packed {
        logic [MZ_W-1:0] lo;
        logic [MZ_W-1:0] hi;
    } win_bounds_t;

endpackage

### sv/spwl_ram.sv
`timescale 1ns / 1ps

module spwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/spwl_window.sv
`timescale 1ns / 1ps

module spwl_window
    import spwl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MZ_W-1:0]  target,
    input  logic [PPM_W-1:0] ppm,
    output logic             done,
    output win_bounds_t      bounds
);

    typedef enum logic [2:0] {
        W_IDLE,
        W_MULH,
        W_MULL,
        W_FIX,
        W_FIN
    } wstate_t;

    wstate_t             state_reg, state_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [PART_W-1:0]   part_reg, part_next;
    logic [DELTA_W-1:0]  quot_reg, quot_next;
    logic [MZ_W-1:0]     tgt_reg, tgt_next;
    win_bounds_t         bounds_reg, bounds_next;
    logic                done_reg, done_next;

    logic [PROD_W-1:0]   product;
    logic [SPLIT_W-1:0]  mul_a;
    logic [PART_W-1:0]   part_mul;
    logic [FULL_W-1:0]   full;
    logic [DVD_W-1:0]    qmul;
    logic [DVD_W-1:0]    rem;
    logic                take;
    logic [MZ_W:0]       sum;

    always_comb
    begin
        product  = PROD_W'(target) * PROD_W'(ppm);
        // one multiplier, upper half of the dividend first, then the lower half
        mul_a    = (state_reg == W_MULH) ? dvd_reg[DVD_W-1:SPLIT_W] : dvd_reg[SPLIT_W-1:0];
        part_mul = PART_W'(mul_a) * PART_W'(WIN_RECIP);
        full     = {part_reg, {SPLIT_W{1'b0}}} + FULL_W'(part_mul);
        qmul     = DVD_W'(quot_reg) * DVD_W'(WIN_DIVISOR);
        rem      = dvd_reg - qmul;
        take     = (rem >= DVD_W'(WIN_DIVISOR));
        sum      = {1'b0, tgt_reg} + (MZ_W+1)'(quot_reg);

        state_next  = state_reg;
        dvd_next    = dvd_reg;
        part_next   = part_reg;
        quot_next   = quot_reg;
        tgt_next    = tgt_reg;
        bounds_next = bounds_reg;
        done_next   = 1'b0;

        case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    tgt_next   = target;
                    dvd_next   = product[PROD_W-1:WIN_SHIFT];
                    state_next = W_MULH;
                end
            end
            W_MULH:
            begin
                part_next  = part_mul;
                state_next = W_MULL;
            end
            W_MULL:
            begin
                quot_next  = full[FULL_W-1:RECIP_SHIFT];
                state_next = W_FIX;
            end
            W_FIX:
            begin
                // estimate can be one low, the remainder tells
                quot_next  = quot_reg + DELTA_W'(take);
                state_next = W_FIN;
            end
            W_FIN:
            begin
                bounds_next.lo = tgt_reg - MZ_W'(quot_reg);
                bounds_next.hi = sum[MZ_W] ? '1 : sum[MZ_W-1:0];
                done_next      = 1'b1;
                state_next     = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= W_IDLE;
            done_reg   <= 1'b0;
            bounds_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            bounds_reg <= bounds_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        part_reg   <= part_next;
        quot_reg   <= quot_next;
        tgt_reg    <= tgt_next;
    end

    assign done   = done_reg;
    assign bounds = bounds_reg;

endmodule

### sv/spectrum_peak_window_lookup_core.sv
`timescale 1ns / 1ps

// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-------------------------------
// request   | in        | in_valid / in_ready   | in_data  (req_t)
// result    | out       | out_valid / out_ready | out_data (rsp_t)
// config    | in        | cfg_we                | cfg_wdata (ppm tolerance)
//
// clear and append: after the request is taken, the result passes through S_OUT into the output register
// range query: a binary search for the first peak at or above lo, then a walk over the matches, both
//   through the single read port of the peak memories
// window query first waits for the bounds from the two-pass reciprocal multiply of the window unit
// reset clears the peak count and sets ppm tolerance to 160; no memory sweep
// a waiting result does not block the next request; a new result waits for
//   the output register

module spectrum_peak_window_lookup_core
    import spwl_pkg::*;
#(
    parameter int PEAK_DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rsp_t             out_data,
    input  logic             cfg_we,
    input  logic [PPM_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(PEAK_DEPTH);
    localparam int CNT_W = $clog2(PEAK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PEAK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_BS_RD,
        S_BS_CMP,
        S_WK_RD,
        S_WK_CHK,
        S_OUT
    } state_t;

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PPM_W-1:0]  ppm_reg, ppm_next;
    logic              out_valid_reg, out_valid_next;

    // query datapath
    logic [MZ_W-1:0]   lo_reg, lo_next;
    logic [MZ_W-1:0]   hi_reg, hi_next;
    logic [MZ_W-1:0]   last_mz_reg, last_mz_next;
    logic [CNT_W-1:0]  bs_lo_reg, bs_lo_next;
    logic [CNT_W-1:0]  bs_hi_reg, bs_hi_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]  match_reg, match_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [INT_W-1:0]  best_int_reg, best_int_next;
    logic              found_reg, found_next;
    rsp_t              res_reg, res_next;
    rsp_t              out_data_reg, out_data_next;

    // memory and window unit hookup
    logic              accept;
    logic              append_ok;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [IDX_W-1:0]  rd_addr;
    logic [MZ_W-1:0]   mz_rd;
    logic [INT_W-1:0]  int_rd;
    logic              win_start;
    logic              win_done;
    win_bounds_t       win_bounds;
    rsp_t              walk_res;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // append is legal when the store has room and m/z does not go backwards
    assign append_ok = (count_reg < DEPTH_CNT) &&
                       ((count_reg == '0) || (in_data.mz_value >= last_mz_reg));

    assign win_start = accept && (in_data.op == OP_WINDOW);

    // binary search midpoint, below the peak count while the search range is not empty
    assign mid_sum = {1'b0, bs_lo_reg} + {1'b0, bs_hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign rd_addr = (state_reg == S_WK_RD) ? k_reg[IDX_W-1:0] : mid[IDX_W-1:0];

    spwl_ram #(
        .WIDTH (MZ_W),
        .DEPTH (PEAK_DEPTH)
    ) u_mz_ram (
        .clk   (clk),
        .we    (accept && (in_data.op == OP_APPEND) && append_ok),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_data.mz_value),
        .raddr (rd_addr),
        .rdata (mz_rd)
    );

    spwl_ram #(
        .WIDTH (INT_W),
        .DEPTH (PEAK_DEPTH)
    ) u_int_ram (
        .clk   (clk),
        .we    (accept && (in_data.op == OP_APPEND) && append_ok),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_data.peak_intensity),
        .raddr (rd_addr),
        .rdata (int_rd)
    );

    spwl_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (win_start),
        .target (in_data.mz_value),
        .ppm    (ppm_reg),
        .done   (win_done),
        .bounds (win_bounds)
    );

    // query result once the walk leaves the window
    always_comb
    begin
        walk_res.status         = ST_OK;
        walk_res.found          = found_reg;
        walk_res.best_index     = BEST_IDX_W'(best_idx_reg);
        walk_res.best_intensity = best_int_reg;
        walk_res.first_index    = (match_reg != '0) ? OUT_CNT_W'(first_reg)
                                                    : OUT_CNT_W'(count_reg);
        walk_res.match_count    = OUT_CNT_W'(match_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ppm_next       = ppm_reg;
        out_valid_next = out_valid_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        last_mz_next   = last_mz_reg;
        bs_lo_next     = bs_lo_reg;
        bs_hi_next     = bs_hi_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        match_next     = match_reg;
        best_idx_next  = best_idx_reg;
        best_int_next  = best_int_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            ppm_next = cfg_wdata;
        end

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next                = '0;
                    res_next.status         = ST_OK;
                    res_next.first_index    = OUT_CNT_W'(count_reg);
                    bs_lo_next              = '0;
                    bs_hi_next              = count_reg;
                    case (in_data.op)
                        OP_CLEAR:
                        begin
                            count_next           = '0;
                            res_next.first_index = '0;
                            state_next           = S_OUT;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg >= DEPTH_CNT)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else if (!append_ok)
                            begin
                                res_next.status = ST_ORDER;
                            end
                            else
                            begin
                                count_next           = count_reg + 1'b1;
                                last_mz_next         = in_data.mz_value;
                                res_next.first_index = OUT_CNT_W'(count_reg + 1'b1);
                            end
                            state_next = S_OUT;
                        end
                        OP_WINDOW:
                        begin
                            state_next = S_WIN;
                        end
                        OP_RANGE:
                        begin
                            lo_next    = in_data.mz_value;
                            hi_next    = in_data.mz_upper;
                            state_next = S_BS_RD;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_WIN:
            begin
                if (win_done)
                begin
                    lo_next    = win_bounds.lo;
                    hi_next    = win_bounds.hi;
                    state_next = S_BS_RD;
                end
            end
            S_BS_RD:
            begin
                // lower bound found: first peak with m/z at or above lo
                if (bs_lo_reg == bs_hi_reg)
                begin
                    k_next        = bs_lo_reg;
                    first_next    = bs_lo_reg;
                    match_next    = '0;
                    best_idx_next = '0;
                    best_int_next = '0;
                    found_next    = 1'b0;
                    state_next    = S_WK_RD;
                end
                else
                begin
                    state_next = S_BS_CMP;
                end
            end
            S_BS_CMP:
            begin
                if (mz_rd < lo_reg)
                begin
                    bs_lo_next = mid + 1'b1;
                end
                else
                begin
                    bs_hi_next = mid;
                end
                state_next = S_BS_RD;
            end
            S_WK_RD:
            begin
                if (k_reg == count_reg)
                begin
                    res_next   = walk_res;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WK_CHK;
                end
            end
            S_WK_CHK:
            begin
                // peaks are sorted, so the first one above hi ends the window
                if (mz_rd > hi_reg)
                begin
                    res_next   = walk_res;
                    state_next = S_OUT;
                end
                else
                begin
                    match_next = match_reg + 1'b1;
                    if (int_rd > best_int_reg)
                    begin
                        best_int_next = int_rd;
                        best_idx_next = k_reg[IDX_W-1:0];
                        found_next    = 1'b1;
                    end
                    k_next     = k_reg + 1'b1;
                    state_next = S_WK_RD;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ppm_reg       <= PPM_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ppm_reg       <= ppm_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        last_mz_reg  <= last_mz_next;
        bs_lo_reg    <= bs_lo_next;
        bs_hi_reg    <= bs_hi_next;
        k_reg        <= k_next;
        first_reg    <= first_next;
        match_reg    <= match_next;
        best_idx_reg <= best_idx_next;
        best_int_reg <= best_int_next;
        found_reg    <= found_next;
        res_reg      <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
